### rtl/ehs_pkg.sv
// ----------------------------------------------------------------------------
// ehs_pkg
// Shared types and constants of the earliest-hit-per-cell selector: field
// widths, request and register codes, and the layout of one cell entry.
// ----------------------------------------------------------------------------
package ehs_pkg;

	// field widths
	localparam int TIME_W  = 32;
	localparam int IDX_W   = 12;
	localparam int DIST_W  = 16;
	localparam int SCALE_W = 20;
	localparam int CFG_W   = 32;

	// drift product and exact arrival sum
	localparam int FRAC_BITS = 16;
	localparam int PROD_W    = DIST_W + SCALE_W + 1;
	localparam int SUM_W     = TIME_W + 2;

	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (FRAC_BITS - 1));
	localparam logic signed [TIME_W-1:0] TIME_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [TIME_W-1:0] TIME_MIN   = 32'sh8000_0000;

	// request codes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// configuration register indexes
	localparam logic CFG_TRIGGER_TIME = 1'b0;
	localparam logic CFG_DRIFT_SCALE  = 1'b1;

	localparam logic signed [TIME_W-1:0] TRIGGER_RESET = '0;
	localparam logic [SCALE_W-1:0]       SCALE_RESET   = 20'd52429;

	// one cell entry as held in the cell memory
	typedef struct packed {
		logic                     occ;
		logic signed [TIME_W-1:0] best_time;
		logic [IDX_W-1:0]         best_index;
	} ehs_entry_t;

	localparam int ENTRY_W = $bits(ehs_entry_t);

endpackage

### rtl/earliest_hit_per_cell_select_top.sv
// ----------------------------------------------------------------------------
// earliest_hit_per_cell_select_top
// Keeps the earliest arrival and its load ordinal for every chamber cell and
// drains the occupied cells in layer-then-cell order.
// ----------------------------------------------------------------------------
// Usage:
//  Input requests (in_valid/in_ready) are either a hit load or a drain.
//  A load produces no result; a drain produces one result on the output
//  channel (out_valid/out_ready): the next occupied cell, or a done result
//  with all other fields zero that restarts the scan and the hit counter.
//  One request is worked on at a time. A load passes through accept,
//  cell memory read, then compare and write back; a load that is ignored
//  ends at the accept. A drain scans the cell memory one entry per cycle
//  until it meets an occupied cell or the end, then emits its result.
//  The result sits in an output register; further loads are accepted while
//  it waits. A drain that finds its cell while a result still waits holds
//  until the receiver takes the older one.
//  After reset the cell memory is cleared one entry per cycle; no request
//  is accepted meanwhile. Configuration writes (cfg_we) are taken at any
//  time and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module earliest_hit_per_cell_select_top import ehs_pkg::*; #(
	parameter int LAYERS          = 20,
	parameter int CELLS_PER_LAYER = 512,
	parameter int MAX_HITS        = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [CFG_W-1:0]         cfg_wdata,
	// input requests
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     opcode,
	input  logic [5:0]               layer,
	input  logic [8:0]               cell_req,
	input  logic signed [TIME_W-1:0] hit_time,
	input  logic signed [DIST_W-1:0] drift_dist,
	// results
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [IDX_W-1:0]         hit_index,
	output logic [5:0]               out_layer,
	output logic [8:0]               out_cell,
	output logic signed [TIME_W-1:0] time_from_trigger,
	output logic                     done_res
);

	localparam int NCELLS = LAYERS * CELLS_PER_LAYER;
	localparam int AW     = $clog2(NCELLS);
	localparam int LW     = $clog2(LAYERS + 1);
	localparam int CW     = $clog2(CELLS_PER_LAYER);
	localparam int CNTW   = $clog2(MAX_HITS + 1);

	typedef struct packed {
		logic [LW-1:0] lyr;
		logic [CW-1:0] cel;
		logic [AW-1:0] addr;
	} pos_t;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_LD_CALC,
		ST_LD_CMP,
		ST_DR_SCAN,
		ST_EMIT
	} state_t;

	state_t                   state_q;
	logic [AW-1:0]            clr_q;
	logic [CNTW-1:0]          hit_cnt_q;
	pos_t                     scan_q;
	pos_t                     pend_s1;
	logic                     pend_v_s1;
	logic [AW-1:0]            ld_addr_q;
	logic [IDX_W-1:0]         ld_ord_q;
	logic signed [TIME_W-1:0] trig_q;
	logic [SCALE_W-1:0]       scale_q;

	logic [IDX_W-1:0]         res_idx_q;
	logic [5:0]               res_layer_q;
	logic [8:0]               res_cell_q;
	logic signed [TIME_W-1:0] res_time_q;
	logic                     res_done_q;

	logic                     accept;
	logic                     cnt_full;
	logic                     in_range;
	logic                     ld_go;
	logic [AW-1:0]            ld_addr;
	logic signed [TIME_W-1:0] arrival;
	ehs_entry_t               rd_entry;
	ehs_entry_t               wr_entry;
	logic [ENTRY_W-1:0]       ram_rdata;
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic                     ram_re;
	logic [AW-1:0]            ram_raddr;
	logic                     ld_win;
	logic                     scan_hit;
	logic                     scan_end;
	logic                     scan_issue;
	logic                     scan_done;
	logic                     out_free;

	// next position in layer-then-cell order
	function automatic pos_t pos_inc(input pos_t p);
		pos_t n;
		n      = p;
		n.addr = p.addr + 1'b1;
		if (p.cel == CW'(CELLS_PER_LAYER - 1)) begin
			n.cel = '0;
			n.lyr = p.lyr + 1'b1;
		end else begin
			n.cel = p.cel + 1'b1;
		end
		return n;
	endfunction

	// request decode
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign cnt_full = (hit_cnt_q == CNTW'(MAX_HITS));
	assign in_range = (32'(layer) < LAYERS) && (32'(cell_req) < CELLS_PER_LAYER);
	assign ld_go    = accept && (opcode == OP_LOAD) && !cnt_full && in_range;
	assign ld_addr  = AW'(AW'(layer) * AW'(CELLS_PER_LAYER) + AW'(cell_req));

	// arrival time pipeline
	ehs_arrival u_arrival (
		.clk          (clk),
		.en           (ld_go),
		.hit_time     (hit_time),
		.drift_dist   (drift_dist),
		.trigger_time (trig_q),
		.drift_scale  (scale_q),
		.arrival      (arrival)
	);

	// cell memory
	ehs_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NCELLS)
	) u_cell_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_entry = ehs_entry_t'(ram_rdata);

	// compare and scan decisions
	assign ld_win     = (state_q == ST_LD_CMP) &&
	                    (!rd_entry.occ || (arrival < rd_entry.best_time));
	assign scan_hit   = (state_q == ST_DR_SCAN) && pend_v_s1 && rd_entry.occ;
	assign scan_end   = (scan_q.lyr == LW'(LAYERS));
	assign scan_issue = (state_q == ST_DR_SCAN) && !scan_hit && !scan_end;
	assign scan_done  = (state_q == ST_DR_SCAN) && !scan_hit && scan_end;
	assign out_free   = !out_valid || out_ready;

	// memory read port
	assign ram_re    = (state_q == ST_LD_CALC) || scan_issue;
	assign ram_raddr = (state_q == ST_LD_CALC) ? ld_addr_q : scan_q.addr;

	// memory write port: clear pass, load update, drain clear
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ld_addr_q;
		wr_entry  = '0;
		case (state_q)
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			ST_LD_CMP: begin
				ram_we              = ld_win;
				wr_entry.occ        = 1'b1;
				wr_entry.best_time  = arrival;
				wr_entry.best_index = ld_ord_q;
			end
			ST_DR_SCAN: begin
				ram_we    = scan_hit;
				ram_waddr = pend_s1.addr;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q  <= TRIGGER_RESET;
			scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TRIGGER_TIME: trig_q  <= $signed(cfg_wdata[TIME_W-1:0]);
				CFG_DRIFT_SCALE:  scale_q <= cfg_wdata[SCALE_W-1:0];
				default:          trig_q  <= trig_q;
			endcase
		end
	end

	// control state machine and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_CLR;
			clr_q             <= '0;
			hit_cnt_q         <= '0;
			scan_q            <= '0;
			pend_v_s1         <= 1'b0;
			out_valid         <= 1'b0;
			hit_index         <= '0;
			out_layer         <= '0;
			out_cell          <= '0;
			time_from_trigger <= '0;
			done_res          <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				out_valid         <= 1'b1;
				hit_index         <= res_idx_q;
				out_layer         <= res_layer_q;
				out_cell          <= res_cell_q;
				time_from_trigger <= res_time_q;
				done_res          <= res_done_q;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end

			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(NCELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (opcode == OP_LOAD) begin
							if (!cnt_full) begin
								hit_cnt_q <= hit_cnt_q + 1'b1;
								if (in_range) begin
									state_q <= ST_LD_CALC;
								end
							end
						end else begin
							pend_v_s1 <= 1'b0;
							state_q   <= ST_DR_SCAN;
						end
					end
				end
				ST_LD_CALC: begin
					state_q <= ST_LD_CMP;
				end
				ST_LD_CMP: begin
					state_q <= ST_IDLE;
				end
				ST_DR_SCAN: begin
					if (scan_hit) begin
						scan_q    <= pos_inc(pend_s1);
						pend_v_s1 <= 1'b0;
						state_q   <= ST_EMIT;
					end else if (!scan_end) begin
						scan_q    <= pos_inc(scan_q);
						pend_v_s1 <= 1'b1;
					end else begin
						scan_q    <= '0;
						hit_cnt_q <= '0;
						pend_v_s1 <= 1'b0;
						state_q   <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// load context, scan read address and pending result
	always_ff @(posedge clk) begin
		if (ld_go) begin
			ld_addr_q <= ld_addr;
			ld_ord_q  <= IDX_W'(hit_cnt_q);
		end
		if (scan_issue) begin
			pend_s1 <= scan_q;
		end
		if (scan_hit) begin
			res_idx_q   <= rd_entry.best_index;
			res_layer_q <= 6'(pend_s1.lyr);
			res_cell_q  <= 9'(pend_s1.cel);
			res_time_q  <= rd_entry.best_time;
			res_done_q  <= 1'b0;
		end else if (scan_done) begin
			res_idx_q   <= '0;
			res_layer_q <= '0;
			res_cell_q  <= '0;
			res_time_q  <= '0;
			res_done_q  <= 1'b1;
		end
	end

	// a scan read is only in flight while draining
	a_pend_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_s1 |-> (state_q == ST_DR_SCAN))
		else $error("scan read pending outside of a drain");

	// the compare step always follows its memory read
	a_cmp_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LD_CMP) |-> ($past(state_q) == ST_LD_CALC))
		else $error("load compare without a preceding read");

	// hit counter never runs past its limit
	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		hit_cnt_q <= CNTW'(MAX_HITS))
		else $error("hit counter beyond limit");

	// the cell memory is never written while waiting for a request
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !ram_we)
		else $error("cell memory written while idle");

endmodule

### rtl/ehs_ram.sv
// ----------------------------------------------------------------------------
// ehs_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module ehs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/ehs_arrival.sv
// ----------------------------------------------------------------------------
// ehs_arrival
// Two-stage arrival time unit: drift times scale product, then rounding,
// sum with hit time, trigger subtraction and saturation to 32 bits.
// ----------------------------------------------------------------------------
module ehs_arrival import ehs_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [TIME_W-1:0] hit_time,
	input  logic signed [DIST_W-1:0] drift_dist,
	input  logic signed [TIME_W-1:0] trigger_time,
	input  logic [SCALE_W-1:0]       drift_scale,
	output logic signed [TIME_W-1:0] arrival
);

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [TIME_W-1:0] time_s1;
	logic signed [PROD_W-1:0] rnd_full;
	logic signed [SUM_W-1:0]  sum;

	// stage 1: signed drift times unsigned Q4.16 scale
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(drift_dist) * PROD_W'($signed({1'b0, drift_scale}));
			time_s1 <= hit_time;
		end
	end

	// round to nearest, ties up, then exact sum
	always_comb begin
		rnd_full = (prod_s1 + ROUND_HALF) >>> FRAC_BITS;
		sum      = SUM_W'(time_s1) + SUM_W'(rnd_full) - SUM_W'(trigger_time);
	end

	// stage 2: saturate to the signed 32 bit range
	always_ff @(posedge clk) begin
		if (sum > SUM_W'(TIME_MAX)) begin
			arrival <= TIME_MAX;
		end else if (sum < SUM_W'(TIME_MIN)) begin
			arrival <= TIME_MIN;
		end else begin
			arrival <= TIME_W'(sum);
		end
	end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the earliest-hit-per-cell selector. A short table
// of hand-picked requests covers extremes, saturation, rounding ties, equal
// and earlier times, ignored hits and loads behind the scan. Random passes of
// loads followed by drains then run under several register settings and
// idling patterns. Every result is checked field by field against a
// cycle-free model of the cell memory kept in the bench.
// ----------------------------------------------------------------------------
module testbench import ehs_pkg::*; ();

	localparam int LAYERS          = 20;
	localparam int CELLS_PER_LAYER = 512;
	localparam int MAX_HITS        = 4096;
	localparam int NCELLS          = LAYERS * CELLS_PER_LAYER;

	localparam int N_ITEMS       = 1750;
	localparam int STALL_LIMIT   = 60000;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 20;

	localparam logic [SCALE_W-1:0] SCALE_MAX = 20'hFFFFF;
	localparam logic [SCALE_W-1:0] SCALE_ONE = 20'h10000;

	typedef struct packed {
		logic                     op;
		logic [5:0]               layer;
		logic [8:0]               cell_no;
		logic signed [TIME_W-1:0] hit_t;
		logic signed [DIST_W-1:0] drift;
	} hit_req_t;

	typedef struct packed {
		logic [IDX_W-1:0]         idx;
		logic [5:0]               layer;
		logic [8:0]               cell_no;
		logic signed [TIME_W-1:0] tft;
		logic                     done;
	} cell_report_t;

	// block ports
	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic                     cfg_index;
	logic [CFG_W-1:0]         cfg_wdata;
	logic                     in_valid;
	logic                     in_ready;
	logic                     opcode;
	logic [5:0]               layer;
	logic [8:0]               cell_req;
	logic signed [TIME_W-1:0] hit_time;
	logic signed [DIST_W-1:0] drift_dist;
	logic                     out_valid;
	logic                     out_ready;
	logic [IDX_W-1:0]         hit_index;
	logic [5:0]               out_layer;
	logic [8:0]               out_cell;
	logic signed [TIME_W-1:0] time_from_trigger;
	logic                     done_res;

	earliest_hit_per_cell_select_top #(
		.LAYERS(LAYERS),
		.CELLS_PER_LAYER(CELLS_PER_LAYER),
		.MAX_HITS(MAX_HITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.layer(layer),
		.cell_req(cell_req),
		.hit_time(hit_time),
		.drift_dist(drift_dist),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit_index(hit_index),
		.out_layer(out_layer),
		.out_cell(out_cell),
		.time_from_trigger(time_from_trigger),
		.done_res(done_res)
	);

	// model of the cell memory and registers
	bit                       occ_mem [NCELLS];
	logic signed [TIME_W-1:0] time_mem [NCELLS];
	logic [IDX_W-1:0]         idx_mem [NCELLS];
	int                       hit_cnt;
	int                       scan_ptr;
	logic signed [TIME_W-1:0] trig_reg;
	logic [SCALE_W-1:0]       scale_reg;

	// bookkeeping
	cell_report_t awaited_reports [$];
	int           errors;
	int           reports_seen;
	int           requests_sent;
	int           counted;
	int           passes;
	int           settings_used;
	int           snd_idle_pct;
	int           rcv_idle_pct;
	bit           last_done;

	// directed table
	hit_req_t     dir_req [$];
	bit           dir_typed [$];
	cell_report_t dir_exp [$];

	// clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic cell_report_t make_report(input int idx, input int lyr, input int cel,
			input logic signed [TIME_W-1:0] tft, input bit done);
		cell_report_t r;
		r.idx     = IDX_W'(idx);
		r.layer   = 6'(lyr);
		r.cell_no = 9'(cel);
		r.tft     = tft;
		r.done    = done;
		return r;
	endfunction

	// advance the cell memory by one request, return 1 when it yields a report
	function automatic bit predict_report(input hit_req_t r, output cell_report_t rep,
			output bit ignored);
		longint prod;
		longint arrival;
		int     p;
		int     ord;
		rep = '0;
		ignored = 1'b0;
		if (r.op == OP_LOAD) begin
			if (hit_cnt >= MAX_HITS) begin
				ignored = 1'b1;
				return 1'b0;
			end
			ord = hit_cnt;
			hit_cnt++;
			if (int'(r.layer) >= LAYERS || int'(r.cell_no) >= CELLS_PER_LAYER) begin
				ignored = 1'b1;
				return 1'b0;
			end
			// round to nearest, ties up, then one saturation of the exact sum
			prod = longint'($signed(r.drift)) * longint'(scale_reg) + 64'sd32768;
			arrival = longint'($signed(r.hit_t)) + (prod >>> FRAC_BITS) - longint'(trig_reg);
			if (arrival > longint'(TIME_MAX))
				arrival = longint'(TIME_MAX);
			if (arrival < longint'(TIME_MIN))
				arrival = longint'(TIME_MIN);
			p = int'(r.layer) * CELLS_PER_LAYER + int'(r.cell_no);
			if (!occ_mem[p] || arrival < longint'(time_mem[p])) begin
				occ_mem[p]  = 1'b1;
				time_mem[p] = TIME_W'(arrival);
				idx_mem[p]  = IDX_W'(ord);
			end
			return 1'b0;
		end
		// drain: next occupied cell in layer-then-cell order
		while (scan_ptr < NCELLS) begin
			p = scan_ptr;
			scan_ptr++;
			if (occ_mem[p]) begin
				occ_mem[p] = 1'b0;
				rep = make_report(idx_mem[p], p / CELLS_PER_LAYER, p % CELLS_PER_LAYER,
					time_mem[p], 1'b0);
				return 1'b1;
			end
		end
		scan_ptr = 0;
		hit_cnt  = 0;
		rep.done = 1'b1;
		return 1'b1;
	endfunction

	function automatic hit_req_t load_req(input int lyr, input int cel,
			input logic signed [TIME_W-1:0] t, input logic signed [DIST_W-1:0] d);
		hit_req_t r;
		r.op      = OP_LOAD;
		r.layer   = 6'(lyr);
		r.cell_no = 9'(cel);
		r.hit_t   = t;
		r.drift   = d;
		return r;
	endfunction

	function automatic hit_req_t drain_req();
		hit_req_t r;
		r = {$urandom, $urandom};
		r.op = OP_DRAIN;
		return r;
	endfunction

	function automatic hit_req_t random_load();
		hit_req_t r;
		r.op = OP_LOAD;
		// a few hot cells at both ends of the memory give ties and replacements
		if ($urandom_range(0, 99) < 30) begin
			r.layer   = $urandom_range(0, 1) ? 6'(LAYERS - 1) : 6'd0;
			r.cell_no = 9'($urandom_range(0, 3)) + ($urandom_range(0, 1) ? 9'd508 : 9'd0);
		end else if ($urandom_range(0, 99) < 90) begin
			r.layer   = 6'($urandom_range(0, LAYERS - 1));
			r.cell_no = 9'($urandom);
		end else begin
			r.layer   = 6'($urandom);
			r.cell_no = 9'($urandom);
		end
		case ($urandom_range(0, 3))
			0: r.hit_t = TIME_W'($urandom_range(0, 7));
			1: r.hit_t = $urandom_range(0, 1) ? TIME_MAX - TIME_W'($urandom_range(0, 3))
				: TIME_MIN + TIME_W'($urandom_range(0, 3));
			default: r.hit_t = TIME_W'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0: r.drift = '0;
			1: r.drift = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			default: r.drift = DIST_W'($urandom);
		endcase
		return r;
	endfunction

	function automatic void add_row(input hit_req_t r, input bit typed, input cell_report_t e);
		dir_req.push_back(r);
		dir_typed.push_back(typed);
		dir_exp.push_back(e);
	endfunction

	function automatic void set_idle(input int mode);
		case (mode)
			0: begin
				snd_idle_pct = 7;
				rcv_idle_pct = 78;
			end
			1: begin
				snd_idle_pct = 78;
				rcv_idle_pct = 7;
			end
			default: begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
		endcase
	endfunction

	task automatic note_mismatch(input string msg);
		errors++;
		$display("mismatch at %0t ns: %s", $realtime, msg);
	endtask

	// offer one request, then update the model once it is taken
	task automatic send_request(input hit_req_t r, input bit typed, input cell_report_t typed_rep);
		cell_report_t rep;
		bit           has_rep;
		bit           ign;
		if ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < snd_idle_pct);
		end
		in_valid   <= 1'b1;
		opcode     <= r.op;
		layer      <= r.layer;
		cell_req   <= r.cell_no;
		hit_time   <= r.hit_t;
		drift_dist <= r.drift;
		do @(posedge clk); while (in_ready !== 1'b1);
		has_rep = predict_report(r, rep, ign);
		if (has_rep)
			awaited_reports.push_back(typed ? typed_rep : rep);
		last_done = has_rep && rep.done;
		if (!ign)
			counted++;
		requests_sent++;
	endtask

	// wait until every result is in and the last load has finished
	task automatic settle();
		in_valid <= 1'b0;
		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic signed [TIME_W-1:0] trig, input logic [SCALE_W-1:0] scale);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TRIGGER_TIME;
		cfg_wdata <= CFG_W'(trig);
		@(posedge clk);
		cfg_index <= CFG_DRIFT_SCALE;
		cfg_wdata <= CFG_W'(scale);
		@(posedge clk);
		cfg_we   <= 1'b0;
		trig_reg  = trig;
		scale_reg = scale;
		settings_used++;
		@(posedge clk);
	endtask

	task automatic apply_setting(input int k);
		case (k % 5)
			0: write_cfg(TRIGGER_RESET, SCALE_RESET);
			1: write_cfg(TIME_MIN, SCALE_MAX);
			2: write_cfg(TIME_MAX, '0);
			3: write_cfg(TIME_W'($urandom), SCALE_W'($urandom));
			default: write_cfg(TIME_W'($urandom_range(0, 2000)) - 1000, SCALE_ONE);
		endcase
	endtask

	// loads with an optional sprinkle of drains, then drains until the done result
	task automatic run_pass(input int n_loads, input int drain_mix);
		hit_req_t r;
		for (int i = 0; i < n_loads; i++) begin
			if ($urandom_range(0, 99) < drain_mix)
				r = drain_req();
			else
				r = random_load();
			send_request(r, 1'b0, '0);
		end
		do begin
			if ($urandom_range(0, 99) < 15)
				send_request(random_load(), 1'b0, '0);
			else
				send_request(drain_req(), 1'b0, '0);
		end while (!last_done);
		passes++;
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin : result_check
		cell_report_t got;
		cell_report_t want;
		out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
		if (arst_n && out_valid && out_ready) begin
			reports_seen++;
			got = {hit_index, out_layer, out_cell, time_from_trigger, done_res};
			if (awaited_reports.size() == 0) begin
				note_mismatch("result with no request waiting for it");
			end else begin
				want = awaited_reports.pop_front();
				if (got.idx !== want.idx)
					note_mismatch($sformatf("hit_index %0d, want %0d", got.idx, want.idx));
				if (got.layer !== want.layer)
					note_mismatch($sformatf("out_layer %0d, want %0d", got.layer, want.layer));
				if (got.cell_no !== want.cell_no)
					note_mismatch($sformatf("out_cell %0d, want %0d",
						got.cell_no, want.cell_no));
				if (got.tft !== want.tft)
					note_mismatch($sformatf("time_from_trigger %0d, want %0d",
						got.tft, want.tft));
				if (got.done !== want.done)
					note_mismatch($sformatf("done_res %0b, want %0b", got.done, want.done));
			end
		end
	end

	// watchdog on cycles without any accepted request or result
	initial begin : watchdog
		int stall;
		stall = 0;
		@(posedge arst_n);
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall = 0;
			else
				stall++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// stimulus
	initial begin : stimulus
		cell_report_t done_rep;
		int           pass_no;
		int           mode;

		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= CFG_TRIGGER_TIME;
		cfg_wdata  <= '0;
		in_valid   <= 1'b0;
		opcode     <= OP_LOAD;
		layer      <= '0;
		cell_req   <= '0;
		hit_time   <= '0;
		drift_dist <= '0;

		hit_cnt   = 0;
		scan_ptr  = 0;
		trig_reg  = TRIGGER_RESET;
		scale_reg = SCALE_RESET;
		last_done = 1'b0;
		pass_no   = 0;
		set_idle(0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hand-picked requests at reset settings
		done_rep = make_report(0, 0, 0, '0, 1'b1);
		add_row(drain_req(), 1'b1, done_rep);                        // empty memory
		add_row(load_req(0, 0, 100, 0), 1'b0, '0);
		add_row(load_req(0, 0, 100, 0), 1'b0, '0);                   // equal time, first stays
		add_row(load_req(LAYERS - 1, 511, TIME_MAX, 16'sh7FFF), 1'b0, '0);
		add_row(load_req(LAYERS - 1, 510, TIME_MIN, 16'sh8000), 1'b0, '0);
		add_row(load_req(LAYERS, 5, 0, 0), 1'b0, '0);                // layer out of range
		add_row(load_req(63, 511, -1, -1), 1'b0, '0);
		add_row(load_req(1, 7, 50, 0), 1'b0, '0);
		add_row(load_req(1, 7, 49, 0), 1'b0, '0);                    // strictly earlier wins
		add_row(load_req(2, 3, 0, 16'sh8000), 1'b0, '0);             // half-way rounding
		add_row(load_req(2, 4, 0, 1), 1'b0, '0);
		add_row(load_req(2, 4, 0, -1), 1'b0, '0);
		add_row(drain_req(), 1'b0, '0);
		add_row(drain_req(), 1'b0, '0);
		add_row(load_req(0, 5, 7, 0), 1'b0, '0);                     // behind the scan
		add_row(drain_req(), 1'b0, '0);
		add_row(drain_req(), 1'b0, '0);
		add_row(drain_req(), 1'b1, make_report(3, LAYERS - 1, 510, TIME_MIN, 1'b0));
		add_row(drain_req(), 1'b1, make_report(2, LAYERS - 1, 511, TIME_MAX, 1'b0));
		add_row(drain_req(), 1'b1, done_rep);
		add_row(drain_req(), 1'b0, '0);
		add_row(drain_req(), 1'b1, done_rep);
		foreach (dir_req[i])
			send_request(dir_req[i], dir_typed[i], dir_exp[i]);
		settle();

		// random passes, register settings change every third pass
		while (requests_sent < N_ITEMS) begin
			if (pass_no % 3 == 0) begin
				settle();
				apply_setting(pass_no / 3);
			end
			mode = requests_sent * 3 / N_ITEMS;
			set_idle(mode);
			run_pass($urandom_range(1, 60), ($urandom_range(0, 7) == 0) ? 10 : 0);
			pass_no++;
		end

		// let the last results come out
		in_valid <= 1'b0;
		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests (%0d in the table), %0d results over %0d drain passes",
			requests_sent, dir_req.size(), reports_seen, passes);
		$display("%0d register settings, %0d requests that touched the cells, three idling patterns",
			settings_used, counted);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
